// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the bridge checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define CHK_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/i2cwb_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cwb_pkg
// Types and constants shared by the I2C to Wishbone bridge files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2cwb_pkg;

  localparam int IN_BITS      = 47;
  localparam int IN_TDATA_W   = 48;
  localparam int OUT_BITS     = 55;
  localparam int OUT_TDATA_W  = 56;
  localparam int LANE_LSB     = 42;
  localparam int LANE_W       = 4;

  localparam logic [7:0] OFFSET_READ_BASE  = 8'd0;
  localparam logic [7:0] OFFSET_WRITE_BASE = 8'd8;

  // Bridge sequencer states, one-hot.
  typedef enum logic [4:0] {
    ST_IDLE       = 5'b00001,
    ST_WRITE      = 5'b00010,
    ST_WRITE_WAIT = 5'b00100,
    ST_READ       = 5'b01000,
    ST_READ_WAIT  = 5'b10000
  } state_t;

  // Input word; the last member sits in the lowest bits.
  typedef struct packed {
    logic [31:0] bus_read_data;
    logic [7:0]  rx_byte;
    logic        bus_ack;
    logic        master_nack;
    logic        ack_done;
    logic        read_ack_tip;
    logic        write_ack_tip;
    logic        addr_ack_tip;
    logic        sync_reset;
  } in_word_t;

  // Result word; the last member sits in the lowest bits.
  typedef struct packed {
    logic        shift_load;
    logic [7:0]  tx_byte;
    logic [3:0]  lane_select;
    logic        bus_write_enable;
    logic        bus_cycle_strobe;
    logic [31:0] bus_write_data;
    logic [7:0]  bus_address;
  } out_word_t;

  // Register updates handed from the sequencer logic to the top level.
  typedef struct packed {
    state_t     state;
    logic [7:0] offset;
  } ctrl_t;

endpackage

// ===== hw/rtl/i2cwb_core.sv =====
// ----------------------------------------------------------------------------
// i2cwb_core
// Next-state, offset and bus output logic for one input word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cwb_core (
  input  i2cwb_pkg::ctrl_t    cur,
  input  i2cwb_pkg::in_word_t word,
  output i2cwb_pkg::ctrl_t    nxt,
  output i2cwb_pkg::out_word_t result
);

  logic       is_read;
  logic [1:0] lane;
  i2cwb_pkg::state_t state_step;

  assign is_read = word.rx_byte[0];
  assign lane    = cur.offset[1:0];

  always_comb begin
    case (cur.state)
      i2cwb_pkg::ST_IDLE: begin
        if (word.addr_ack_tip && word.ack_done) begin
          state_step = is_read ? i2cwb_pkg::ST_READ : i2cwb_pkg::ST_WRITE_WAIT;
        end else begin
          state_step = i2cwb_pkg::ST_IDLE;
        end
      end
      i2cwb_pkg::ST_WRITE: begin
        state_step = word.bus_ack ? i2cwb_pkg::ST_WRITE_WAIT : i2cwb_pkg::ST_WRITE;
      end
      i2cwb_pkg::ST_WRITE_WAIT: begin
        if (word.addr_ack_tip) begin
          state_step = i2cwb_pkg::ST_IDLE;
        end else if (word.write_ack_tip && word.ack_done) begin
          state_step = i2cwb_pkg::ST_WRITE;
        end else begin
          state_step = i2cwb_pkg::ST_WRITE_WAIT;
        end
      end
      i2cwb_pkg::ST_READ: begin
        state_step = word.bus_ack ? i2cwb_pkg::ST_READ_WAIT : i2cwb_pkg::ST_READ;
      end
      i2cwb_pkg::ST_READ_WAIT: begin
        if (word.addr_ack_tip) begin
          state_step = i2cwb_pkg::ST_IDLE;
        end else if (word.read_ack_tip && word.ack_done) begin
          state_step = word.master_nack ? i2cwb_pkg::ST_IDLE : i2cwb_pkg::ST_READ;
        end else begin
          state_step = i2cwb_pkg::ST_READ_WAIT;
        end
      end
      default: begin
        state_step = i2cwb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    nxt.state = word.sync_reset ? i2cwb_pkg::ST_IDLE : state_step;
    // The offset ignores the bridge reset; an address acknowledge wins over a count.
    if (word.addr_ack_tip) begin
      nxt.offset = is_read ? i2cwb_pkg::OFFSET_READ_BASE : i2cwb_pkg::OFFSET_WRITE_BASE;
    end else if (word.ack_done) begin
      nxt.offset = cur.offset + 8'd1;
    end else begin
      nxt.offset = cur.offset;
    end
  end

  always_comb begin
    result.bus_address      = cur.offset;
    result.bus_write_data   = {4{word.rx_byte}};
    result.bus_cycle_strobe = (cur.state == i2cwb_pkg::ST_WRITE) ||
                              (cur.state == i2cwb_pkg::ST_READ);
    result.bus_write_enable = (cur.state == i2cwb_pkg::ST_WRITE);
    result.lane_select      = 4'b0001 << lane;
    result.tx_byte          = word.bus_read_data[{lane, 3'b000} +: 8];
    result.shift_load       = (cur.state == i2cwb_pkg::ST_READ);
  end

endmodule

// ===== hw/rtl/i2c_to_wishbone_bridge_fsm.sv =====
// ----------------------------------------------------------------------------
// i2c_to_wishbone_bridge_fsm
// Sequencer that turns I2C slave acknowledge events into Wishbone cycles.
// ----------------------------------------------------------------------------
// Each input word carries one clock's worth of I2C slave flags, the received
// byte and the Wishbone read word; each accepted word yields exactly one
// registered result word, holding the bus address, the replicated write
// data, cycle/strobe, write enable, the one-hot lane select, the selected read
// byte and the shifter load. The result is computed from the state held before
// the word and the word itself, and the state and byte offset advance when the
// word is accepted. Throughput is one word per clock: the single output
// register frees up in the same cycle it is taken downstream, so s_tready only
// drops while a finished result sits unaccepted. m_tvalid rises in the cycle
// after an input is accepted, set by that output register.
`timescale 1ns / 1ps

module i2c_to_wishbone_bridge_fsm (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // From bit 0: sync_reset, addr_ack_tip, write_ack_tip, read_ack_tip,
  // ack_done, master_nack, bus_ack, rx_byte[7:0], bus_read_data[31:0], pad.
  input  logic [i2cwb_pkg::IN_TDATA_W-1:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // From bit 0: bus_address[7:0], bus_write_data[31:0], bus_cycle_strobe,
  // bus_write_enable, lane_select[3:0], tx_byte[7:0], shift_load, pad.
  output logic [i2cwb_pkg::OUT_TDATA_W-1:0] m_tdata
);

  i2cwb_pkg::ctrl_t     ctrl;
  i2cwb_pkg::ctrl_t     ctrl_next;
  i2cwb_pkg::in_word_t  in_word;
  i2cwb_pkg::out_word_t result_next;
  i2cwb_pkg::out_word_t result;
  logic                 accept;

  assign in_word  = i2cwb_pkg::in_word_t'(s_tdata[i2cwb_pkg::IN_BITS-1:0]);
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  i2cwb_core u_core (
    .cur    (ctrl),
    .word   (in_word),
    .nxt    (ctrl_next),
    .result (result_next)
  );

  // Sequencer state and byte offset move only when a word is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.state  <= i2cwb_pkg::ST_IDLE;
      ctrl.offset <= 8'd0;
    end else if (accept) begin
      ctrl <= ctrl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Result payload needs no reset; it is loaded with every accepted word.
  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  assign m_tdata = {{(i2cwb_pkg::OUT_TDATA_W - i2cwb_pkg::OUT_BITS){1'b0}}, result};

endmodule

// ===== hw/rtl/i2cwb_checker.sv =====
// ----------------------------------------------------------------------------
// i2cwb_checker
// Port-level assertions for the bridge, attached to the top level by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module i2cwb_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [i2cwb_pkg::IN_TDATA_W-1:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [i2cwb_pkg::OUT_TDATA_W-1:0] m_tdata
);

  logic [i2cwb_pkg::LANE_W-1:0] lanes;
  logic                         in_take;
  logic                         out_stall;

  assign lanes     = m_tdata[i2cwb_pkg::LANE_LSB +: i2cwb_pkg::LANE_W];
  assign in_take   = s_tvalid && s_tready;
  assign out_stall = m_tvalid && !m_tready;

  // Input is refused only while an unaccepted result is held.
  `CHK_ASSERT(a_ready_rule, clk, rst, s_tready == (!m_tvalid || m_tready), "s_tready wrong")
  // Every accepted word produces a result on the next cycle.
  `CHK_ASSERT(a_result_follows, clk, rst, in_take |=> m_tvalid, "result missing")
  // A stalled result holds.
  `CHK_ASSERT(a_stall_hold, clk, rst, out_stall |=> (m_tvalid && $stable(m_tdata)), "result changed")
  // The lane select is always a single lane.
  `CHK_ASSERT(a_lane_onehot, clk, rst, m_tvalid |-> $onehot(lanes), "lane select not one-hot")
  // No result is shown in the first cycle after reset is released.
  `CHK_ASSERT_ALWAYS(a_reset_empty, clk, ($past(rst) && !rst) |-> !m_tvalid, "valid after reset")

endmodule

bind i2c_to_wishbone_bridge_fsm i2cwb_checker u_i2cwb_checker (.*);
